### rtl/core/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg
// Shared types and constants of the escape-time color unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mec_pkg;

   localparam int LIMB_W       = 32;
   localparam int CNT_W        = 16;
   localparam int COLOR_W      = 8;
   localparam int DIV_DEN_W    = 3 * CNT_W;
   localparam int DIV_NUM_W    = DIV_DEN_W + COLOR_W;
   localparam int ESC_BOUND    = 5;
   localparam int ESC_BOUND_SQ = 25;
   localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(35);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_MUL_GO   = 7'b0000010,
      ST_MUL_WAIT = 7'b0000100,
      ST_UPDATE   = 7'b0001000,
      ST_DIV_GO   = 7'b0010000,
      ST_DIV_WAIT = 7'b0100000,
      ST_FINISH   = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      OP_XY,
      OP_XX,
      OP_YY,
      OP_JJ,
      OP_JJJ,
      OP_NN,
      OP_NNN
   } mul_op_type;

   typedef enum logic [1:0] {
      SEL_BLUE,
      SEL_GREEN,
      SEL_RED
   } color_sel_type;

endpackage

`default_nettype wire

### rtl/core/mandelbrot_escape_color.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_color
// Escape-time iteration of z = z*z + c with integer color mapping.
// ----------------------------------------------------------------------------
// One point at a time: req_ready is high only while the unit is idle, and the
// finished beat sits in an output register so the next point can be taken
// while it waits. All multiplies run on one shared iterative multiplier
// (32x32 limbs) and all divides on one bit-serial divider. Two limbs are
// used when there are more than 29 fraction bits, else one. Each iteration
// multiplies out the cross product, then the two squares. An escaped point
// then runs four more multiplies and three 8-step divides for the colors.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_color
   import mec_pkg::*;
#(
   parameter int COORD_WIDTH     = 36,
   parameter int COORD_FRAC_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [CNT_W-1:0]              csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_c_real,
   input  logic signed [COORD_WIDTH-1:0] req_c_imag,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_escaped,
   output logic [CNT_W-1:0]              rsp_escape_count,
   output logic [COLOR_W-1:0]            rsp_red,
   output logic [COLOR_W-1:0]            rsp_green,
   output logic [COLOR_W-1:0]            rsp_blue
);

   localparam int W     = COORD_WIDTH;
   localparam int F     = COORD_FRAC_BITS;
   localparam int ZW    = F + 4;
   localparam int MAG_W = F + 3;
   localparam int LIMBS = (MAG_W + LIMB_W - 1) / LIMB_W;
   localparam int MW    = LIMBS * LIMB_W;
   localparam int PW    = 2 * MW;
   localparam int SQ_W  = 2 * F + 5;
   localparam int AW    = ((2 * F + 7 > W + F) ? 2 * F + 7 : W + F) + 2;
   localparam int NW    = AW - F;

   localparam logic signed [NW-1:0] BOUND_POS = NW'(ESC_BOUND) << F;
   localparam logic signed [NW-1:0] BOUND_NEG = -BOUND_POS;
   localparam logic [SQ_W:0]        SQ_LIMIT  = (SQ_W + 1)'(ESC_BOUND_SQ) << (2 * F);

   state_type      state_ff, state_in;
   mul_op_type     op_ff, op_in;
   color_sel_type  sel_ff, sel_in;
   logic [CNT_W-1:0] max_iter_ff;

   logic signed [W-1:0]  cr_ff, cr_in, ci_ff, ci_in;
   logic signed [ZW-1:0] zx_ff, zx_in, zy_ff, zy_in;
   logic [SQ_W-1:0]      sx_ff, sx_in, sy_ff, sy_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   logic                 esc_ff, esc_in;
   logic [2*CNT_W-1:0]   jsq_ff, jsq_in, nsq_ff, nsq_in;
   logic [3*CNT_W-1:0]   jcu_ff, jcu_in, ncu_ff, ncu_in;
   logic [COLOR_W-1:0]   red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_escaped_ff;
   logic [CNT_W-1:0]     rsp_count_ff;
   logic [COLOR_W-1:0]   rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                 load_rsp;

   logic                 mul_start, mul_done;
   logic [MW-1:0]        mul_a, mul_b;
   logic [PW-1:0]        mul_prod;
   logic                 div_start, div_done;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [3*CNT_W-1:0]   div_x;
   logic [COLOR_W-1:0]   div_quo;

   logic [ZW-1:0]          zx_mag, zy_mag;
   logic [SQ_W-1:0]        p_mag;
   logic signed [AW-1:0]   two_p, cr_sh, ci_sh, rx, ry;
   logic signed [NW-1:0]   nx, ny;
   logic                   bound_hit;
   logic [SQ_W:0]          sq_sum;

   mec_mul #(
      .LIMBS (LIMBS)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod),
      .done  (mul_done)
   );

   mec_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

   assign zx_mag = zx_ff[ZW-1] ? (~zx_ff + 1'b1) : zx_ff;
   assign zy_mag = zy_ff[ZW-1] ? (~zy_ff + 1'b1) : zy_ff;

   always_comb begin
      case (op_ff)
         OP_XY:   begin mul_a = MW'(zx_mag[ZW-2:0]); mul_b = MW'(zy_mag[ZW-2:0]); end
         OP_XX:   begin mul_a = MW'(zx_mag[ZW-2:0]); mul_b = MW'(zx_mag[ZW-2:0]); end
         OP_YY:   begin mul_a = MW'(zy_mag[ZW-2:0]); mul_b = MW'(zy_mag[ZW-2:0]); end
         OP_JJ:   begin mul_a = MW'(j_ff);           mul_b = MW'(j_ff);           end
         OP_JJJ:  begin mul_a = MW'(jsq_ff);         mul_b = MW'(j_ff);           end
         OP_NN:   begin mul_a = MW'(max_iter_ff);    mul_b = MW'(max_iter_ff);    end
         OP_NNN:  begin mul_a = MW'(nsq_ff);         mul_b = MW'(max_iter_ff);    end
         default: begin mul_a = '0;                  mul_b = '0;                  end
      endcase
   end

   assign mul_start = (state_ff == ST_MUL_GO);
   assign div_start = (state_ff == ST_DIV_GO);

   always_comb begin
      case (sel_ff)
         SEL_BLUE:  begin div_x = DIV_DEN_W'(j_ff);   div_den = DIV_DEN_W'(max_iter_ff); end
         SEL_GREEN: begin div_x = DIV_DEN_W'(jsq_ff); div_den = DIV_DEN_W'(nsq_ff);      end
         SEL_RED:   begin div_x = jcu_ff;             div_den = ncu_ff;                  end
         default:   begin div_x = '0;                 div_den = '0;                      end
      endcase
   end

   // 255*x as (x << 8) - x
   assign div_num = (DIV_NUM_W'(div_x) << COLOR_W) - DIV_NUM_W'(div_x);

   // z update: cross product from the multiplier, squares from the last test
   assign p_mag     = mul_prod[SQ_W-1:0];
   assign two_p     = (zx_ff[ZW-1] ^ zy_ff[ZW-1]) ? -AW'({p_mag, 1'b0}) : AW'({p_mag, 1'b0});
   assign cr_sh     = AW'(cr_ff) <<< F;
   assign ci_sh     = AW'(ci_ff) <<< F;
   assign rx        = AW'(sx_ff) - AW'(sy_ff) + cr_sh;
   assign ry        = two_p + ci_sh;
   assign nx        = rx[AW-1:F];
   assign ny        = ry[AW-1:F];
   assign bound_hit = (nx > BOUND_POS) || (nx < BOUND_NEG) ||
                      (ny > BOUND_POS) || (ny < BOUND_NEG);
   assign sq_sum    = (SQ_W + 1)'(sx_ff) + (SQ_W + 1)'(mul_prod[SQ_W-1:0]);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      sel_in   = sel_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      zx_in    = zx_ff;
      zy_in    = zy_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      j_in     = j_ff;
      esc_in   = esc_ff;
      jsq_in   = jsq_ff;
      jcu_in   = jcu_ff;
      nsq_in   = nsq_ff;
      ncu_in   = ncu_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cr_in  = req_c_real;
               ci_in  = req_c_imag;
               zx_in  = '0;
               zy_in  = '0;
               sx_in  = '0;
               sy_in  = '0;
               j_in   = '0;
               esc_in = 1'b0;
               op_in  = OP_XY;
               state_in = (max_iter_ff == '0) ? ST_FINISH : ST_MUL_GO;
            end
         end
         ST_MUL_GO: begin
            state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = ST_MUL_GO;
               case (op_ff)
                  OP_XY: begin
                     state_in = ST_UPDATE;
                  end
                  OP_XX: begin
                     sx_in = mul_prod[SQ_W-1:0];
                     op_in = OP_YY;
                  end
                  OP_YY: begin
                     sy_in = mul_prod[SQ_W-1:0];
                     if (sq_sum > SQ_LIMIT) begin
                        esc_in = 1'b1;
                        op_in  = OP_JJ;
                     end else if (j_ff == max_iter_ff - 1'b1) begin
                        state_in = ST_FINISH;
                     end else begin
                        j_in  = j_ff + 1'b1;
                        op_in = OP_XY;
                     end
                  end
                  OP_JJ: begin
                     jsq_in = mul_prod[2*CNT_W-1:0];
                     op_in  = OP_JJJ;
                  end
                  OP_JJJ: begin
                     jcu_in = mul_prod[3*CNT_W-1:0];
                     op_in  = OP_NN;
                  end
                  OP_NN: begin
                     nsq_in = mul_prod[2*CNT_W-1:0];
                     op_in  = OP_NNN;
                  end
                  OP_NNN: begin
                     ncu_in   = mul_prod[3*CNT_W-1:0];
                     sel_in   = SEL_BLUE;
                     state_in = ST_DIV_GO;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_UPDATE: begin
            state_in = ST_MUL_GO;
            if (bound_hit) begin
               esc_in = 1'b1;
               op_in  = OP_JJ;
            end else begin
               zx_in = nx[ZW-1:0];
               zy_in = ny[ZW-1:0];
               op_in = OP_XX;
            end
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               case (sel_ff)
                  SEL_BLUE: begin
                     blue_in  = div_quo;
                     sel_in   = SEL_GREEN;
                     state_in = ST_DIV_GO;
                  end
                  SEL_GREEN: begin
                     green_in = div_quo;
                     sel_in   = SEL_RED;
                     state_in = ST_DIV_GO;
                  end
                  SEL_RED: begin
                     red_in   = div_quo;
                     state_in = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign load_rsp     = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_XY;
         sel_ff       <= SEL_BLUE;
         max_iter_ff  <= MAX_ITER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            max_iter_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      zx_ff    <= zx_in;
      zy_ff    <= zy_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      j_ff     <= j_in;
      esc_ff   <= esc_in;
      jsq_ff   <= jsq_in;
      jcu_ff   <= jcu_in;
      nsq_ff   <= nsq_in;
      ncu_ff   <= ncu_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      if (load_rsp) begin
         rsp_escaped_ff <= esc_ff;
         rsp_count_ff   <= esc_ff ? j_ff     : '0;
         rsp_red_ff     <= esc_ff ? red_ff   : '0;
         rsp_green_ff   <= esc_ff ? green_ff : '0;
         rsp_blue_ff    <= esc_ff ? blue_ff  : '0;
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_escaped      = rsp_escaped_ff;
   assign rsp_escape_count = rsp_count_ff;
   assign rsp_red          = rsp_red_ff;
   assign rsp_green        = rsp_green_ff;
   assign rsp_blue         = rsp_blue_ff;

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result beat raised outside finish");

   a_black_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_escaped_ff |->
         rsp_count_ff == '0 && rsp_red_ff == '0 && rsp_green_ff == '0 && rsp_blue_ff == '0)
      else $error("bounded point with nonzero count or color");

   a_color_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_escaped_ff |->
         rsp_red_ff <= rsp_green_ff && rsp_green_ff <= rsp_blue_ff &&
         rsp_count_ff < max_iter_ff)
      else $error("escape colors out of order or count past limit");

   a_mul_done_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MUL_WAIT)
      else $error("multiplier finished while sequencer not waiting");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished while sequencer not waiting");

endmodule

`default_nettype wire

### rtl/core/mec_mul.sv
// ----------------------------------------------------------------------------
// mec_mul
// Iterative unsigned multiplier: one 32x32 limb product per cycle, registered,
// then shifted into a wide accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module mec_mul
   import mec_pkg::*;
#(
   parameter int LIMBS = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [LIMBS*LIMB_W-1:0]       a,
   input  logic [LIMBS*LIMB_W-1:0]       b,
   output logic [2*LIMBS*LIMB_W-1:0]     prod,
   output logic                          done
);

   localparam int MW    = LIMBS * LIMB_W;
   localparam int PW    = 2 * MW;
   localparam int PP_W  = 2 * LIMB_W;
   localparam int IDX_W = (LIMBS > 1) ? $clog2(LIMBS) : 1;
   localparam int SH_W  = $clog2(2 * LIMBS);

   logic [MW-1:0]     a_ff, a_in, b_ff, b_in;
   logic [IDX_W-1:0]  i_ff, i_in, k_ff, k_in;
   logic              issue_ff, issue_in;
   logic [PP_W-1:0]   pp_ff, pp_in;
   logic [SH_W-1:0]   ppsh_ff, ppsh_in;
   logic              pp_valid_ff, pp_valid_in;
   logic              pp_last_ff, pp_last_in;
   logic [PW-1:0]     acc_ff, acc_in;
   logic              done_ff, done_in;

   logic [MW-1:0]     a_sh, b_sh;
   logic [LIMB_W-1:0] a_limb, b_limb;
   logic              last;

   always_comb begin
      a_sh   = a_ff >> (LIMB_W * i_ff);
      b_sh   = b_ff >> (LIMB_W * k_ff);
      a_limb = a_sh[LIMB_W-1:0];
      b_limb = b_sh[LIMB_W-1:0];
      last   = (i_ff == IDX_W'(LIMBS - 1)) && (k_ff == IDX_W'(LIMBS - 1));

      a_in        = a_ff;
      b_in        = b_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      issue_in    = issue_ff;
      pp_in       = pp_ff;
      ppsh_in     = ppsh_ff;
      pp_valid_in = 1'b0;
      pp_last_in  = 1'b0;
      acc_in      = acc_ff;
      done_in     = 1'b0;

      if (pp_valid_ff) begin
         acc_in  = acc_ff + (PW'(pp_ff) << (LIMB_W * ppsh_ff));
         done_in = pp_last_ff;
      end

      if (start) begin
         a_in     = a;
         b_in     = b;
         i_in     = '0;
         k_in     = '0;
         issue_in = 1'b1;
         acc_in   = '0;
      end else if (issue_ff) begin
         pp_in       = PP_W'(a_limb) * PP_W'(b_limb);
         ppsh_in     = SH_W'(i_ff) + SH_W'(k_ff);
         pp_valid_in = 1'b1;
         pp_last_in  = last;
         if (last) begin
            issue_in = 1'b0;
         end else if (k_ff == IDX_W'(LIMBS - 1)) begin
            k_in = '0;
            i_in = i_ff + 1'b1;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff    <= 1'b0;
         pp_valid_ff <= 1'b0;
         pp_last_ff  <= 1'b0;
         done_ff     <= 1'b0;
         i_ff        <= '0;
         k_ff        <= '0;
      end else begin
         issue_ff    <= issue_in;
         pp_valid_ff <= pp_valid_in;
         pp_last_ff  <= pp_last_in;
         done_ff     <= done_in;
         i_ff        <= i_in;
         k_ff        <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      pp_ff   <= pp_in;
      ppsh_ff <= ppsh_in;
      acc_ff  <= acc_in;
   end

   assign prod = acc_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

### rtl/core/mec_div.sv
// ----------------------------------------------------------------------------
// mec_div
// Restoring divider for color scaling: one quotient bit per cycle, quotient
// known to stay below 256.
// ----------------------------------------------------------------------------
`default_nettype none

module mec_div
   import mec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIV_NUM_W-1:0]  num,
   input  logic [DIV_DEN_W-1:0]  den,
   output logic [COLOR_W-1:0]    quo,
   output logic                  done
);

   localparam int STEP_W = $clog2(COLOR_W);

   logic [DIV_NUM_W-1:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [COLOR_W-1:0]   q_ff, q_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = num;
         dsh_in  = DIV_NUM_W'(den) << (COLOR_W - 1);
         q_in    = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[COLOR_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[COLOR_W-2:0], 1'b0};
         end
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(COLOR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign quo  = q_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

### tb/mandelbrot_escape_color_tb.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_color_tb
// Self-checking bench for the escape-time color unit.
// ----------------------------------------------------------------------------
// Points go into a queue that a clocked driver feeds to the request channel.
// Each accepted point is run through a local escape-time model at 128-bit
// precision, and the expected pixel is queued. A clocked monitor takes result
// beats under random back-pressure and compares them field by field. The run
// starts with corner points and directed points at limits 1, 0, 2 and 65535,
// then random phases at limits including 1 and 65535, with drains between.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_color_tb;
   import mec_pkg::CNT_W;
   import mec_pkg::COLOR_W;

   localparam int COORD_W = 36;
   localparam int FRAC    = 32;

   localparam logic signed [COORD_W-1:0] ONE   = 36'sh1_0000_0000;
   localparam logic signed [COORD_W-1:0] MAX_C = 36'sh7_FFFF_FFFF;
   localparam logic signed [COORD_W-1:0] MIN_C = 36'sh8_0000_0000;

   typedef struct packed {
      logic signed [COORD_W-1:0] re;
      logic signed [COORD_W-1:0] im;
   } point_t;

   typedef struct packed {
      logic               escaped;
      logic [CNT_W-1:0]   count;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CNT_W-1:0]          csr_write_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_c_real = '0;
   logic signed [COORD_W-1:0] req_c_imag = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_escaped;
   logic [CNT_W-1:0]          rsp_escape_count;
   logic [COLOR_W-1:0]        rsp_red;
   logic [COLOR_W-1:0]        rsp_green;
   logic [COLOR_W-1:0]        rsp_blue;

   point_t           point_queue[$];
   pixel_t           expected_pixels[$];
   point_t           next_point;
   pixel_t           rsp_want;
   logic [CNT_W-1:0] iteration_limit = mec_pkg::MAX_ITER_RESET;
   bit               no_idle = 1'b0;
   int               error_count = 0;
   int               pixels_checked = 0;
   int               escaped_seen = 0;

   mandelbrot_escape_color #(
      .COORD_WIDTH     (COORD_W),
      .COORD_FRAC_BITS (FRAC)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_c_real       (req_c_real),
      .req_c_imag       (req_c_imag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_escaped      (rsp_escaped),
      .rsp_escape_count (rsp_escape_count),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue)
   );

   always #1 clock = ~clock;

   // escape-time iteration at full width, then exact integer color scaling
   function automatic pixel_t predict_pixel(input logic signed [COORD_W-1:0] c_re,
                                            input logic signed [COORD_W-1:0] c_im,
                                            input logic [CNT_W-1:0] limit);
      logic signed [127:0] cr, ci, zx, zy, rx, ry, nx, ny, bound, mag_limit;
      int unsigned         step;
      longint unsigned     n, j;
      pixel_t              pix;
      cr = c_re;
      ci = c_im;
      cr = cr <<< FRAC;
      ci = ci <<< FRAC;
      bound = 128'sd5 <<< FRAC;
      mag_limit = 128'sd25 <<< (2 * FRAC);
      zx = '0;
      zy = '0;
      pix = '0;
      for (step = 0; step < limit; step++) begin
         rx = zx * zx - zy * zy + cr;
         ry = ((zx * zy) <<< 1) + ci;
         nx = rx >>> FRAC;
         ny = ry >>> FRAC;
         if (nx > bound || nx < -bound || ny > bound || ny < -bound) begin
            pix.escaped = 1'b1;
            pix.count = CNT_W'(step);
            break;
         end
         zx = nx;
         zy = ny;
         if (zx * zx + zy * zy > mag_limit) begin
            pix.escaped = 1'b1;
            pix.count = CNT_W'(step);
            break;
         end
      end
      if (pix.escaped && limit != 0) begin
         n = limit;
         j = pix.count;
         pix.red   = COLOR_W'((255 * j * j * j) / (n * n * n));
         pix.green = COLOR_W'((255 * j * j) / (n * n));
         pix.blue  = COLOR_W'((255 * j) / n);
      end
      return pix;
   endfunction

   task automatic report_mismatch(input string field, input longint unsigned got,
                                  input longint unsigned want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch at pixel %0d: %s = %0d, expected %0d",
                  pixels_checked, field, got, want);
   endtask

   // driver: one beat per handshake, random gaps unless no_idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_pixels.push_back(predict_pixel(req_c_real, req_c_imag,
                                                    iteration_limit));
         if (!req_valid || req_ready) begin
            if (point_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 17)) begin
               next_point = point_queue.pop_front();
               req_valid  <= 1'b1;
               req_c_real <= next_point.re;
               req_c_imag <= next_point.im;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure unless no_idle, compare against oldest expected pixel
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               rsp_want = expected_pixels.pop_front();
               if (rsp_escaped !== rsp_want.escaped)
                  report_mismatch("escaped", rsp_escaped, rsp_want.escaped);
               if (rsp_escape_count !== rsp_want.count)
                  report_mismatch("escape_count", rsp_escape_count, rsp_want.count);
               if (rsp_red !== rsp_want.red)
                  report_mismatch("red", rsp_red, rsp_want.red);
               if (rsp_green !== rsp_want.green)
                  report_mismatch("green", rsp_green, rsp_want.green);
               if (rsp_blue !== rsp_want.blue)
                  report_mismatch("blue", rsp_blue, rsp_want.blue);
               pixels_checked++;
               if (rsp_want.escaped)
                  escaped_seen++;
            end
         end
         rsp_ready <= no_idle || ($urandom_range(0, 99) >= 17);
      end
   end

   task automatic queue_point(input logic signed [COORD_W-1:0] re,
                              input logic signed [COORD_W-1:0] im);
      point_t p;
      p.re = re;
      p.im = im;
      point_queue.push_back(p);
   endtask

   task automatic drain();
      do
         @(negedge clock);
      while (point_queue.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_limit(input logic [CNT_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      iteration_limit = value;
      @(negedge clock);
   endtask

   // value in [lo_q/4, (lo_q+span_q)/4) with random fraction bits
   function automatic logic signed [COORD_W-1:0] quarter_span(input int lo_q,
                                                              input int span_q);
      logic [63:0]        r;
      logic signed [63:0] v;
      r = {$urandom, $urandom};
      v = lo_q;
      v = v <<< 30;
      v = v + $signed(r % (64'(span_q) << 30));
      return v[COORD_W-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] random_coord(input int mode);
      logic [63:0] r;
      r = {$urandom, $urandom};
      case (mode)
         0: return quarter_span(-9, 12);
         1: return quarter_span(-5, 10);
         2: return quarter_span(-24, 48);
         3: begin
            case ($urandom_range(0, 5))
               0: return '0;
               1: return 5 * ONE;
               2: return -5 * ONE;
               3: return MAX_C;
               4: return MIN_C;
               default: return 36'sd1;
            endcase
         end
         default: return r[COORD_W-1:0];
      endcase
   endfunction

   task automatic run_random_phase(input logic [CNT_W-1:0] limit, input int count,
                                   input bit calm);
      int pick, half, k;
      drain();
      set_limit(limit);
      no_idle = calm;
      for (half = 0; half < 2; half++) begin
         for (k = 0; k < count / 2; k++) begin
            pick = $urandom_range(0, 99);
            if (limit == 16'hFFFF)
               // far right half-plane: escapes within a few steps
               queue_point(quarter_span(10, 20), quarter_span(-32, 64));
            else if (pick < 60)
               queue_point(random_coord(0), random_coord(1));
            else if (pick < 75)
               queue_point(random_coord(2), random_coord(2));
            else if (pick < 85)
               queue_point(random_coord(3), random_coord(3));
            else
               queue_point(random_coord(4), random_coord(4));
         end
         // sender holds off until every pixel is back
         drain();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corners at the reset limit
      queue_point('0, '0);
      queue_point(MAX_C, MAX_C);
      queue_point(MIN_C, MIN_C);
      queue_point(MAX_C, MIN_C);
      queue_point(MIN_C, MAX_C);
      queue_point(-2 * ONE, '0);
      queue_point(ONE / 4, '0);
      queue_point(2 * ONE, '0);
      queue_point(5 * ONE, '0);
      queue_point(5 * ONE + 1, '0);
      queue_point('0, 5 * ONE);
      queue_point(3 * ONE, 4 * ONE);
      queue_point(3 * ONE + 1, 4 * ONE);
      queue_point(36'shF_4000_0000, 36'sh0_1999_999A);
      queue_point('0, ONE);
      drain();

      set_limit(16'd1);
      queue_point(2 * ONE, '0);
      queue_point('0, -5 * ONE - 1);
      drain();

      // zero limit: no step, black
      set_limit(16'd0);
      queue_point('0, '0);
      queue_point(MAX_C, MAX_C);
      drain();

      set_limit(16'd2);
      queue_point(2 * ONE, '0);
      queue_point(-2 * ONE, '0);
      drain();

      set_limit(16'hFFFF);
      queue_point(6 * ONE, '0);
      queue_point(2 * ONE, '0);
      queue_point(MAX_C, '0);

      run_random_phase(16'd35, 120, 1'b0);
      run_random_phase(16'd8, 80, 1'b0);
      run_random_phase(16'd64, 100, 1'b1);
      run_random_phase(16'd1, 40, 1'b0);
      run_random_phase(16'd200, 40, 1'b0);
      run_random_phase(16'd1000, 8, 1'b0);
      run_random_phase(16'hFFFF, 12, 1'b0);
      run_random_phase(CNT_W'($urandom_range(2, 48)), 100, 1'b0);

      drain();
      repeat (100) @(negedge clock);
      if (expected_pixels.size() != 0)
         report_mismatch("pixels never returned", 0, expected_pixels.size());
      $display("checked %0d pixels, %0d of them escaped, with iteration limits", 
               pixels_checked, escaped_seen);
      $display("0, 1, 2, 8, 35, 64, 200, 1000, 65535 and one random small limit");
      if (error_count == 0)
         $display("mandelbrot_escape_color_tb: PASS");
      else
         $display("mandelbrot_escape_color_tb: FAIL");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timed out waiting for the unit");
      $display("mandelbrot_escape_color_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/core/mec_pkg.sv
rtl/core/mec_mul.sv
rtl/core/mec_div.sv
rtl/core/mandelbrot_escape_color.sv
tb/mandelbrot_escape_color_tb.sv
